>>> hw/rtl/fmpf_pkg.sv
package fmpf_pkg;

    localparam logic       DIR_TX     = 1'b0;
    localparam logic       DIR_RX     = 1'b1;
    localparam logic [7:0] MASK_RESET = 8'h66;
    localparam logic [8:0] MOD_SUM    = 9'd255;

    localparam int RES_SLOTS = 3;

    // register index of the configuration port
    typedef enum logic [0:0] {
        REG_DIRECTION = 1'b0,
        REG_XOR_MASK  = 1'b1
    } cfg_reg_t;

    typedef enum logic [1:0] {
        STATUS_OK        = 2'd0,
        STATUS_MISMATCH  = 2'd1,
        STATUS_TOO_SHORT = 2'd2
    } status_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_packet;
    } item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_present;
        logic       packet_done;
        logic [1:0] status;
    } result_t;

    // all results caused by one item, slot 0 leaves first
    typedef struct packed {
        result_t [RES_SLOTS-1:0] slot;
        logic [1:0]              count;
    } bundle_t;

    typedef struct packed {
        logic       direction;
        logic [7:0] xor_mask;
        logic       clear;
    } ctrl_t;

    // one running sum step modulo 255, operands in 0..254 or any byte
    function automatic logic [7:0] mod255_add(input logic [7:0] a, input logic [7:0] b);
        logic [8:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= MOD_SUM)
        begin
            s = s - MOD_SUM;
        end
        return s[7:0];
    endfunction

endpackage

>>> hw/rtl/fmpf_in_if.sv
interface fmpf_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       end_of_packet;

    modport source (output valid, output data_byte, output end_of_packet, input ready);
    modport sink (input valid, input data_byte, input end_of_packet, output ready);
endinterface

>>> hw/rtl/fmpf_out_if.sv
interface fmpf_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       byte_present;
    logic       packet_done;
    logic [1:0] status;

    modport source (output valid, output out_byte, output byte_present,
                    output packet_done, output status, input ready);
    modport sink (input valid, input out_byte, input byte_present,
                  input packet_done, input status, output ready);
endinterface

>>> hw/rtl/fmpf_engine.sv
module fmpf_engine (
    input  logic             clk,
    input  logic             rst_n,
    input  fmpf_pkg::ctrl_t  ctrl,
    input  logic             load,
    input  fmpf_pkg::item_t  item,
    output fmpf_pkg::bundle_t bundle
);

    logic [7:0] low_sum_reg, low_sum_next;
    logic [7:0] high_sum_reg, high_sum_next;
    logic [1:0] held_count_reg, held_count_next;
    logic [7:0] held0_reg, held0_next;
    logic [7:0] held1_reg, held1_next;

    logic [7:0]  add_in;
    logic [7:0]  low_add;
    logic [7:0]  high_add;
    logic [7:0]  plain;
    logic [15:0] rx_word;
    logic [15:0] calc_word;
    fmpf_pkg::status_t rx_status;

    assign plain    = held0_reg ^ ctrl.xor_mask;
    assign add_in   = (ctrl.direction == fmpf_pkg::DIR_TX) ? item.data_byte : plain;
    assign low_add  = fmpf_pkg::mod255_add(low_sum_reg, add_in);
    assign high_add = fmpf_pkg::mod255_add(high_sum_reg, low_add);

    // trailer check at packet end
    always_comb
    begin
        rx_word   = '0;
        calc_word = '0;
        rx_status = fmpf_pkg::STATUS_TOO_SHORT;
        case (held_count_reg)
            2'd2:
            begin
                rx_word   = {held1_reg, item.data_byte};
                calc_word = {high_add, low_add};
                rx_status = (rx_word == calc_word) ? fmpf_pkg::STATUS_OK
                                                   : fmpf_pkg::STATUS_MISMATCH;
            end
            2'd1:
            begin
                rx_word   = {held0_reg, item.data_byte};
                calc_word = {high_sum_reg, low_sum_reg};
                rx_status = (rx_word == calc_word) ? fmpf_pkg::STATUS_OK
                                                   : fmpf_pkg::STATUS_MISMATCH;
            end
            default:
            begin
                rx_status = fmpf_pkg::STATUS_TOO_SHORT;
            end
        endcase
    end

    always_comb
    begin
        low_sum_next    = low_sum_reg;
        high_sum_next   = high_sum_reg;
        held_count_next = held_count_reg;
        held0_next      = held0_reg;
        held1_next      = held1_reg;
        bundle          = '0;

        if (ctrl.direction == fmpf_pkg::DIR_TX)
        begin
            low_sum_next  = low_add;
            high_sum_next = high_add;
            bundle.slot[0].out_byte     = item.data_byte ^ ctrl.xor_mask;
            bundle.slot[0].byte_present = 1'b1;
            bundle.count                = 2'd1;
            if (item.end_of_packet)
            begin
                bundle.slot[1].out_byte     = high_add;
                bundle.slot[1].byte_present = 1'b1;
                bundle.slot[2].out_byte     = low_add;
                bundle.slot[2].byte_present = 1'b1;
                bundle.slot[2].packet_done  = 1'b1;
                bundle.slot[2].status       = fmpf_pkg::STATUS_OK;
                bundle.count                = 2'd3;
                low_sum_next    = '0;
                high_sum_next   = '0;
                held_count_next = '0;
            end
        end
        else
        begin
            if (held_count_reg == 2'd2)
            begin
                // oldest held byte leaves the delay line
                low_sum_next  = low_add;
                high_sum_next = high_add;
                held0_next    = held1_reg;
                held1_next    = item.data_byte;
                bundle.slot[0].out_byte     = plain;
                bundle.slot[0].byte_present = 1'b1;
                bundle.count                = 2'd1;
            end
            else
            begin
                if (held_count_reg[0])
                begin
                    held1_next = item.data_byte;
                end
                else
                begin
                    held0_next = item.data_byte;
                end
                held_count_next = held_count_reg + 2'd1;
            end

            if (item.end_of_packet)
            begin
                if (held_count_reg == 2'd2)
                begin
                    bundle.slot[1].packet_done = 1'b1;
                    bundle.slot[1].status      = rx_status;
                    bundle.count               = 2'd2;
                end
                else
                begin
                    bundle.slot[0].packet_done = 1'b1;
                    bundle.slot[0].status      = rx_status;
                    bundle.count               = 2'd1;
                end
                low_sum_next    = '0;
                high_sum_next   = '0;
                held_count_next = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            low_sum_reg    <= '0;
            high_sum_reg   <= '0;
            held_count_reg <= '0;
        end
        else if (ctrl.clear)
        begin
            low_sum_reg    <= '0;
            high_sum_reg   <= '0;
            held_count_reg <= '0;
        end
        else if (load)
        begin
            low_sum_reg    <= low_sum_next;
            high_sum_reg   <= high_sum_next;
            held_count_reg <= held_count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            held0_reg <= held0_next;
            held1_reg <= held1_next;
        end
    end

endmodule

>>> hw/rtl/fmpf_outstage.sv
module fmpf_outstage (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               load,
    input  fmpf_pkg::bundle_t  bundle,
    output logic               free,
    fmpf_out_if.source         result
);

    fmpf_pkg::result_t [fmpf_pkg::RES_SLOTS-1:0] slot_reg;
    logic [1:0] count_reg, count_next;
    logic [1:0] idx_reg, idx_next;
    fmpf_pkg::result_t head;
    logic pop;
    logic last;

    always_comb
    begin
        case (idx_reg)
            2'd0:    head = slot_reg[0];
            2'd1:    head = slot_reg[1];
            2'd2:    head = slot_reg[2];
            default: head = slot_reg[0];
        endcase
    end

    assign result.valid        = (count_reg != 2'd0);
    assign result.out_byte     = head.out_byte;
    assign result.byte_present = head.byte_present;
    assign result.packet_done  = head.packet_done;
    assign result.status       = head.status;

    assign pop  = result.valid && result.ready;
    assign last = (idx_reg == (count_reg - 2'd1));
    assign free = (count_reg == 2'd0) || (pop && last);

    always_comb
    begin
        count_next = count_reg;
        idx_next   = idx_reg;
        if (load)
        begin
            count_next = bundle.count;
            idx_next   = '0;
        end
        else if (pop)
        begin
            if (last)
            begin
                count_next = '0;
                idx_next   = '0;
            end
            else
            begin
                idx_next = idx_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            idx_reg   <= '0;
        end
        else
        begin
            count_reg <= count_next;
            idx_reg   <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            slot_reg <= bundle.slot;
        end
    end

endmodule

>>> hw/rtl/fletcher16_masked_payload_framer_unit.sv
// Masked payload framer with a Fletcher-16 trailer. Each transaction on item carries
// one packet byte; end_of_packet marks the last one. With direction 0 every byte
// leaves XORed with xor_mask and a Fletcher-16 checksum runs over the original bytes;
// the packet's last byte is followed by two trailer bytes, high sum first, the second
// with packet_done set. With direction 1 the last two bytes received are held back
// as the trailer: older bytes leave unmasked and are checksummed, and at packet end
// one status-only result (byte_present 0, packet_done 1) reports ok, mismatch, or too
// short for a packet under two bytes. Writing direction drops any partial packet.
// Configuration is to be written only while the block is idle, which the block
// itself does not enforce. Timing: a byte goes through an input register and the
// checksum/format logic into a result register, from which its results are offered.
// One byte is taken per cycle while each byte causes at most one result and the
// receiver is ready; the result register drains one result per cycle while the
// receiver is ready, so a transmit packet end (three results) or a receive packet
// end with a payload byte (two results) holds the input until the last is taken.
module fletcher16_masked_payload_framer_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [0:0]  cfg_index,
    input  logic [7:0]  cfg_wdata,
    fmpf_in_if.sink     item,
    fmpf_out_if.source  result
);

    // configuration registers
    logic       direction_reg;
    logic [7:0] xor_mask_reg;

    // input register
    logic              in_valid_reg, in_valid_next;
    fmpf_pkg::item_t   in_item_reg;

    logic              accept;
    logic              load;
    logic              free;
    fmpf_pkg::ctrl_t   ctrl;
    fmpf_pkg::bundle_t bundle;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            direction_reg <= fmpf_pkg::DIR_TX;
            xor_mask_reg  <= fmpf_pkg::MASK_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                fmpf_pkg::REG_DIRECTION: direction_reg <= cfg_wdata[0];
                fmpf_pkg::REG_XOR_MASK:  xor_mask_reg  <= cfg_wdata;
                default:                 xor_mask_reg  <= xor_mask_reg;
            endcase
        end
    end

    // a direction write restarts the packet
    assign ctrl.direction = direction_reg;
    assign ctrl.xor_mask  = xor_mask_reg;
    assign ctrl.clear     = cfg_we && (cfg_index == fmpf_pkg::REG_DIRECTION);

    // the held byte moves on once the result register can take all its results
    assign load       = in_valid_reg && free;
    assign item.ready = !in_valid_reg || load;
    assign accept     = item.valid && item.ready;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (accept)
        begin
            in_valid_next = 1'b1;
        end
        else if (load)
        begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_item_reg.data_byte     <= item.data_byte;
            in_item_reg.end_of_packet <= item.end_of_packet;
        end
    end

    // running sums, trailer delay line and result formatting
    fmpf_engine u_engine (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (ctrl),
        .load   (load),
        .item   (in_item_reg),
        .bundle (bundle)
    );

    // result register, drained one result per transaction
    fmpf_outstage u_outstage (
        .clk    (clk),
        .rst_n  (rst_n),
        .load   (load),
        .bundle (bundle),
        .free   (free),
        .result (result)
    );

endmodule

>>> bench/fmpf_checker.sv
module fmpf_checker (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic [0:0] cfg_index,
    input  logic [7:0] cfg_wdata,
    fmpf_in_if         item_mon,
    fmpf_out_if        res_mon,
    output int         mismatch_count,
    output int         frame_out_left
);
    timeunit 1ns;
    timeprecision 1ps;

    logic                 dir_q;
    logic [7:0]           mask_q;
    logic [7:0]           lo_sum;
    logic [7:0]           hi_sum;
    logic [7:0]           held [2];
    logic [1:0]           held_n;
    fmpf_pkg::result_t    frame_out_q [$];
    fmpf_pkg::result_t    want;
    int                   mismatches = 0;

    assign mismatch_count = mismatches;

    function automatic logic [7:0] add_mod255(input logic [7:0] a, input logic [7:0] b);
        int s;
        s = int'(a) + int'(b);
        return (s >= 255) ? 8'(s - 255) : 8'(s);
    endfunction

    function automatic void sum_in(input logic [7:0] b);
        lo_sum = add_mod255(lo_sum, b);
        hi_sum = add_mod255(hi_sum, lo_sum);
    endfunction

    function automatic void clear_packet();
        lo_sum = 8'h00;
        hi_sum = 8'h00;
        held_n = 2'd0;
    endfunction

    function automatic void queue_out(input logic [7:0] b, input logic present,
                                      input logic done, input fmpf_pkg::status_t st);
        fmpf_pkg::result_t r;
        r.out_byte     = b;
        r.byte_present = present;
        r.packet_done  = done;
        r.status       = st;
        frame_out_q.push_back(r);
    endfunction

    // results caused by one accepted byte
    task automatic frame_byte(input logic [7:0] b, input logic eop);
        logic [7:0]         plain;
        fmpf_pkg::status_t  st;
        if (dir_q == fmpf_pkg::DIR_TX)
        begin
            sum_in(b);
            queue_out(b ^ mask_q, 1'b1, 1'b0, fmpf_pkg::STATUS_OK);
            if (eop)
            begin
                queue_out(hi_sum, 1'b1, 1'b0, fmpf_pkg::STATUS_OK);
                queue_out(lo_sum, 1'b1, 1'b1, fmpf_pkg::STATUS_OK);
                clear_packet();
            end
        end
        else
        begin
            if (held_n == 2'd2)
            begin
                plain = held[0] ^ mask_q;
                sum_in(plain);
                queue_out(plain, 1'b1, 1'b0, fmpf_pkg::STATUS_OK);
                held[0] = held[1];
                held[1] = b;
            end
            else
            begin
                held[held_n[0]] = b;
                held_n = held_n + 2'd1;
            end
            if (eop)
            begin
                if (held_n != 2'd2)
                    st = fmpf_pkg::STATUS_TOO_SHORT;
                else if ({held[0], held[1]} == {hi_sum, lo_sum})
                    st = fmpf_pkg::STATUS_OK;
                else
                    st = fmpf_pkg::STATUS_MISMATCH;
                queue_out(8'h00, 1'b0, 1'b1, st);
                clear_packet();
            end
        end
    endtask

    task automatic report(input string field, input int got, input int exp_val);
        mismatches++;
        $display("%0t ns: %s got %0h want %0h", $realtime, field, got, exp_val);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dir_q  = fmpf_pkg::DIR_TX;
            mask_q = fmpf_pkg::MASK_RESET;
            held[0] = 8'h00;
            held[1] = 8'h00;
            clear_packet();
            frame_out_q.delete();
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == fmpf_pkg::REG_DIRECTION)
                begin
                    dir_q = cfg_wdata[0];
                    clear_packet();
                end
                else if (cfg_index == fmpf_pkg::REG_XOR_MASK)
                begin
                    mask_q = cfg_wdata;
                end
            end
            if (item_mon.valid && item_mon.ready)
                frame_byte(item_mon.data_byte, item_mon.end_of_packet);
            if (res_mon.valid && res_mon.ready)
            begin
                if (frame_out_q.size() == 0)
                begin
                    report("result with none pending, out_byte", res_mon.out_byte, 0);
                end
                else
                begin
                    want = frame_out_q.pop_front();
                    if (res_mon.out_byte !== want.out_byte)
                        report("out_byte", res_mon.out_byte, want.out_byte);
                    if (res_mon.byte_present !== want.byte_present)
                        report("byte_present", res_mon.byte_present, want.byte_present);
                    if (res_mon.packet_done !== want.packet_done)
                        report("packet_done", res_mon.packet_done, want.packet_done);
                    if (res_mon.status !== want.status)
                        report("status", res_mon.status, want.status);
                end
            end
        end
        frame_out_left <= frame_out_q.size();
    end

endmodule

>>> bench/fletcher16_masked_payload_framer_unit_tb.sv
module fletcher16_masked_payload_framer_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    // generous bound, well above what the slowest correct run needs
    localparam int CYCLE_LIMIT = 300000;
    // long receiver hold-off, well beyond the block's internal buffering
    localparam int LONG_HOLD   = 100;
    // random transactions per direction in each idling phase
    localparam int HALF_ITEMS  = 47;

    logic       clk = 1'b0;
    logic       rst_n;
    logic       cfg_we;
    logic [0:0] cfg_index;
    logic [7:0] cfg_wdata;

    fmpf_in_if  item_ch ();
    fmpf_out_if res_ch ();

    int         mismatch_count;
    int         frame_out_left;

    // idling knobs, percent of cycles
    int         send_idle_pct  = 0;
    int         recv_stall_pct = 0;

    // long hold requests are served by the receiver process itself
    int         hold_req_n     = 0;
    int         hold_served_n  = 0;
    int         hold_left      = 0;

    int         cycle_n        = 0;
    int         phase_items;
    logic [7:0] cur_mask;

    fletcher16_masked_payload_framer_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .item      (item_ch),
        .result    (res_ch)
    );

    fmpf_checker chk (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .item_mon       (item_ch),
        .res_mon        (res_ch),
        .mismatch_count (mismatch_count),
        .frame_out_left (frame_out_left)
    );

    always #10ns clk = ~clk;

    // watchdog on total run length
    always @(posedge clk)
    begin
        cycle_n <= cycle_n + 1;
        if (cycle_n == CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    // receiver: random stalls, plus a long hold-off whenever one is requested
    always @(posedge clk)
    begin
        if (hold_req_n != hold_served_n)
        begin
            hold_served_n = hold_req_n;
            hold_left     = LONG_HOLD;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            res_ch.ready <= 1'b0;
        end
        else
        begin
            res_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // offer one byte, with random idle cycles ahead of it; valid stays high
    // afterwards so back-to-back transactions follow without a gap
    task automatic send_byte(input logic [7:0] b, input logic eop);
        while ($urandom_range(99) < send_idle_pct)
        begin
            item_ch.valid <= 1'b0;
            @(posedge clk);
        end
        item_ch.valid         <= 1'b1;
        item_ch.data_byte     <= b;
        item_ch.end_of_packet <= eop;
        @(posedge clk);
        while (!item_ch.ready)
            @(posedge clk);
        phase_items++;
    endtask

    // stop offering and wait until every predicted result has been taken;
    // the extra cycles cover receive bytes that cause no result yet
    task automatic settle();
        item_ch.valid <= 1'b0;
        @(posedge clk);
        while (frame_out_left != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_reg(input fmpf_pkg::cfg_reg_t idx, input logic [7:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        @(posedge clk);
        if (idx == fmpf_pkg::REG_XOR_MASK)
            cur_mask = value;
    endtask

    task automatic tx_packet(input int len);
        for (int i = 0; i < len; i++)
            send_byte(8'($urandom_range(255)), i == len - 1);
    endtask

    // well-formed receive packet: masked payload, then the raw checksum of the
    // plain payload, high byte first; a bad trailer gets one bit flipped
    task automatic rx_packet(input int payload_len, input bit good_trailer);
        logic [7:0]  body [$];
        logic [15:0] trailer;
        int          lo;
        int          hi;
        lo = 0;
        hi = 0;
        for (int i = 0; i < payload_len; i++)
        begin
            body.push_back(8'($urandom_range(255)));
            lo = (lo + body[i]) % 255;
            hi = (hi + lo) % 255;
        end
        trailer = {8'(hi), 8'(lo)};
        if (!good_trailer)
            trailer = trailer ^ (16'h0001 << $urandom_range(15));
        for (int i = 0; i < payload_len; i++)
            send_byte(body[i] ^ cur_mask, 1'b0);
        send_byte(trailer[15:8], 1'b0);
        send_byte(trailer[7:0], 1'b1);
    endtask

    // arbitrary bytes closing with end of packet, short packets included
    task automatic rx_noise(input int len);
        for (int i = 0; i < len; i++)
            send_byte(8'($urandom_range(255)), i == len - 1);
    endtask

    initial
    begin
        int r;
        cfg_we                = 1'b0;
        cfg_index             = fmpf_pkg::REG_DIRECTION;
        cfg_wdata             = 8'h00;
        item_ch.valid         = 1'b0;
        item_ch.data_byte     = 8'h00;
        item_ch.end_of_packet = 1'b0;
        res_ch.ready          = 1'b0;
        cur_mask              = fmpf_pkg::MASK_RESET;
        phase_items           = 0;
        rst_n                 = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: transmit with the reset mask
        send_byte(8'h00, 1'b1);              // single-byte packet, all-zero sums
        send_byte(8'hff, 1'b0);              // sums wrap modulo 255
        send_byte(8'hff, 1'b0);
        send_byte(8'hff, 1'b1);
        send_byte(8'ha5, 1'b0);              // mask change mid-packet keeps the sums
        send_byte(8'h5a, 1'b0);
        settle();
        write_reg(fmpf_pkg::REG_XOR_MASK, 8'h00);
        send_byte(8'h80, 1'b1);
        send_byte(8'h01, 1'b0);              // partial packet dropped by a direction write
        settle();
        write_reg(fmpf_pkg::REG_DIRECTION, 8'(fmpf_pkg::DIR_RX));
        write_reg(fmpf_pkg::REG_XOR_MASK, 8'hff);

        // directed: receive
        send_byte(8'h7e, 1'b1);              // packet too short
        rx_packet(0, 1'b1);                  // empty payload, trailer 0x0000
        send_byte(8'h00, 1'b0);              // empty payload, wrong trailer
        send_byte(8'h01, 1'b1);
        rx_packet(1, 1'b1);
        rx_packet(3, 1'b0);
        send_byte(8'h3c, 1'b0);              // partial receive packet, then abort
        send_byte(8'hc3, 1'b0);
        settle();
        write_reg(fmpf_pkg::REG_DIRECTION, 8'(fmpf_pkg::DIR_TX));
        send_byte(8'h7f, 1'b1);              // sums start from zero after the abort

        // random: four idling phases, each with a transmit and a receive half
        for (int ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1:       begin send_idle_pct = 64; recv_stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  recv_stall_pct = 64; end
                default: begin send_idle_pct = 19; recv_stall_pct = 19; end
            endcase

            // transmit half
            settle();
            write_reg(fmpf_pkg::REG_DIRECTION, 8'(fmpf_pkg::DIR_TX));
            write_reg(fmpf_pkg::REG_XOR_MASK, (ph == 0) ? 8'h00 : 8'($urandom_range(255)));
            phase_items = 0;
            while (phase_items < HALF_ITEMS)
            begin
                // long hold-off while the sender keeps pushing, so input backs up
                if (ph == 0 && phase_items >= 10 && hold_req_n == 0)
                    hold_req_n++;
                tx_packet(($urandom_range(9) == 0) ? 1 : $urandom_range(2, 8));
            end

            // receive half, mostly well-formed packets
            settle();
            write_reg(fmpf_pkg::REG_DIRECTION, 8'(fmpf_pkg::DIR_RX));
            write_reg(fmpf_pkg::REG_XOR_MASK, (ph == 1) ? 8'hff : 8'($urandom_range(255)));
            phase_items = 0;
            while (phase_items < HALF_ITEMS)
            begin
                r = $urandom_range(99);
                if (r < 65)
                    rx_packet($urandom_range(0, 6), 1'b1);
                else if (r < 85)
                    rx_packet($urandom_range(0, 6), 1'b0);
                else
                    rx_noise($urandom_range(1, 4));
            end
        end

        settle();
        if (mismatch_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
